FILE: hdl/antialiased_snake_activation_core_defines.svh
// Assertion macros shared by the anti-aliased snake activation RTL.
`ifndef ANTIALIASED_SNAKE_ACTIVATION_CORE_DEFINES_SVH
`define ANTIALIASED_SNAKE_ACTIVATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is suspended while reset is held.
`define ASA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also covers the reset cycles.
`define ASA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASA_CHECK(lbl, prop, msg)
`define ASA_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/asa_pkg.sv
// Types, constants and tables of the anti-aliased snake activation core.
package asa_pkg;

  localparam int DATA_W     = 24;
  localparam int CFG_W      = 24;
  localparam int HIST_DEPTH = 12;
  localparam int TAP_W      = 17;
  localparam int CW         = 34;

  localparam logic [33:0] PI_Q32      = 34'd13493037705;
  localparam logic [33:0] HALF_PI_Q32 = 34'd6746518852;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032875;

  // Configuration register indexes.
  localparam logic REG_SNAKE_FREQ    = 1'b0;
  localparam logic REG_SNAKE_INV_MAG = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_OUT_INIT, S_UP_INIT, S_UP_MUL, S_UP_ACC, S_ARG_MUL, S_ARG_WAIT,
    S_QUO, S_REM_HI, S_REM_LO, S_MOD, S_FOLD, S_CORDIC, S_SQ_MUL, S_SQ_WAIT,
    S_GAIN_MUL, S_GAIN_WAIT, S_DN_MUL, S_DN_ACC
  } asa_state_t;

  typedef enum logic {
    E_WAIT, E_GO
  } asa_emit_t;

  // Half-band kernel taps in Q16, symmetric.
  function automatic logic signed [TAP_W-1:0] asa_tap(input logic [3:0] idx);
    logic signed [TAP_W-1:0] v;
    case (idx)
      4'd0, 4'd11: v = 17'sd133;
      4'd1, 4'd10: v = 17'sd615;
      4'd2, 4'd9:  v = -17'sd1674;
      4'd3, 4'd8:  v = -17'sd3779;
      4'd4, 4'd7:  v = 17'sd8426;
      4'd5, 4'd6:  v = 17'sd29046;
      default:     v = '0;
    endcase
    return v;
  endfunction

  // CORDIC angle table, atan(2^-i) in Q30.
  function automatic logic signed [CW-1:0] asa_atan(input logic [3:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      4'd0:    v = 34'sd843314857;
      4'd1:    v = 34'sd497837830;
      4'd2:    v = 34'sd263043837;
      4'd3:    v = 34'sd133525159;
      4'd4:    v = 34'sd67021687;
      4'd5:    v = 34'sd33543516;
      4'd6:    v = 34'sd16775851;
      4'd7:    v = 34'sd8388438;
      4'd8:    v = 34'sd4194283;
      4'd9:    v = 34'sd2097149;
      4'd10:   v = 34'sd1048576;
      4'd11:   v = 34'sd524288;
      4'd12:   v = 34'sd262144;
      4'd13:   v = 34'sd131072;
      4'd14:   v = 34'sd65536;
      default: v = 34'sd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/antialiased_snake_activation_core.sv
// Top level of the anti-aliased snake activation: sequencer, history and datapath.
//
//   Channel   Dir  Signals                          Item
//   in_       in   in_tvalid/tready/tdata/tlast     sample_in[23:0], last_in
//   out_      out  out_tvalid/tready/tdata/tlast    sample_out[23:0], last_out
//   cfg_      in   cfg_we/cfg_addr/cfg_wdata        0 snake_freq, 1 snake_inv_mag
//
// Each result needs twelve upsampled values, each with six MACs, a reduction
// modulo pi by reciprocal multiplication and a 16-step CORDIC; all but the
// CORDIC go through one shared multiplier. An item yields zero to six results;
// an item that yields none is taken while the sequencer stays idle.
// in_tready is high only while the sequencer is idle; the output register holds
// a result until it is taken and the sequencer waits on it. Reset is synchronous.
`include "antialiased_snake_activation_core_defines.svh"
module antialiased_snake_activation_core import asa_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // [23:0] sample_in
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [23:0] sample_out
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int MW     = (SAMPLE_BITS + 1 > 32) ? SAMPLE_BITS + 1 : 32;
  localparam int PW     = 2 * MW;
  localparam int AW     = SAMPLE_BITS + 24;
  localparam int QW     = AW - 34;
  localparam int QSH    = 88 - AW;
  localparam int UACC_W = DATA_W + 17;
  localparam int OACC_W = SAMPLE_BITS + 18;
  localparam int VS_W   = ((SAMPLE_BITS > 27) ? SAMPLE_BITS : 27) + 2;

  // Reciprocal of pi scaled by 2^28, applied to the top 28 argument bits.
  localparam logic [26:0] RECIP_PI = 27'((64'd1 << 60) / 64'(PI_Q32));

  localparam logic signed [UACC_W-1:0] U_HI =
    UACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [UACC_W-1:0] U_LO = ~U_HI;
  localparam logic signed [VS_W-1:0] V_HI =
    VS_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [VS_W-1:0] V_LO = ~V_HI;
  localparam logic signed [OACC_W-1:0] O_HI =
    OACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [OACC_W-1:0] O_LO = ~O_HI;

  asa_state_t state_r, state_nxt;
  asa_emit_t  emit;

  logic [CFG_W-1:0] freq_r, inv_mag_r;
  logic signed [DATA_W-1:0] hist_r [HIST_DEPTH];
  logic [4:0] seen_r;
  logic [3:0] cur_n_r, o_r, o_end_r, t_r, k_r;
  logic       last_r, ph_r;
  logic [2:0] s_r;
  logic signed [UACC_W-1:0] acc_up_r;
  logic signed [OACC_W-1:0] acc_out_r;
  logic signed [SAMPLE_BITS-1:0] u_r, v_r;
  logic [AW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [17:0]   s2_r;
  logic          out_valid_r, out_last_r;
  logic [23:0]   out_data_r;

  logic in_fire, cord_start, cord_done;
  logic signed [CW-1:0] cord_y, cord_z;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Upsampled index and its edge clamps.
  logic signed [7:0] j_w, jmax_w;
  logic [7:0]        jc_w;
  always_comb begin
    j_w    = $signed({3'b0, o_r, 1'b0}) + $signed({4'b0, t_r}) - 8'sd5;
    jmax_w = $signed({3'b0, cur_n_r, 1'b1});
    if (j_w < 8'sd0) begin
      jc_w = '0;
    end else if (j_w > jmax_w) begin
      jc_w = jmax_w;
    end else begin
      jc_w = j_w;
    end
  end

  // Sample index of this MAC, clamped to the sequence, mapped to a history slot.
  logic signed [6:0] i_w;
  logic [3:0]        ic_w, d_w, dsel_w;
  logic [3:0]        up_tap_idx;
  always_comb begin
    i_w = $signed({3'b0, k_r}) + (ph_r ? 7'sd3 : 7'sd2) - $signed({4'b0, s_r});
    if (i_w < 7'sd0) begin
      ic_w = '0;
    end else if (i_w > $signed({3'b0, cur_n_r})) begin
      ic_w = cur_n_r;
    end else begin
      ic_w = i_w[3:0];
    end
    d_w    = cur_n_r - ic_w;
    dsel_w = (d_w > 4'd11) ? 4'd11 : d_w;
    up_tap_idx = ph_r ? {s_r, 1'b0} : {s_r, 1'b1};
  end

  // Upsampled value rounded and saturated, and its magnitude.
  logic signed [UACC_W-1:0]      u_rnd;
  logic signed [SAMPLE_BITS-1:0] u_w;
  logic [SAMPLE_BITS-1:0]        umag;
  always_comb begin
    u_rnd = (acc_up_r + UACC_W'(32'sd16384)) >>> 15;
    if (u_rnd > U_HI) begin
      u_w = U_HI[SAMPLE_BITS-1:0];
    end else if (u_rnd < U_LO) begin
      u_w = U_LO[SAMPLE_BITS-1:0];
    end else begin
      u_w = u_rnd[SAMPLE_BITS-1:0];
    end
    umag = u_w[SAMPLE_BITS-1] ? (~u_w + 1'b1) : u_w;
  end

  // Argument fold into [-pi/2, pi/2] and conversion to Q30.
  logic signed [34:0] rs_w, zr_w;
  always_comb begin
    if (rem_r[33:0] > HALF_PI_Q32) begin
      rs_w = $signed({1'b0, rem_r[33:0]}) - $signed({1'b0, PI_Q32});
    end else begin
      rs_w = $signed({1'b0, rem_r[33:0]});
    end
    zr_w   = (rs_w + 35'sd2) >>> 2;
    cord_z = zr_w[CW-1:0];
  end

  // Squared sine, gain and activated value.
  logic [CW-1:0]   ay_full;
  logic [PW-1:0]   sq_tmp, gn_tmp;
  logic [26:0]     gain_w;
  logic signed [VS_W-1:0] vsum;
  logic signed [SAMPLE_BITS-1:0] v_w;
  always_comb begin
    ay_full = cord_y[CW-1] ? (~cord_y + 1'b1) : cord_y;
    sq_tmp  = prod + (PW'(1) << 43);
    gn_tmp  = prod + PW'(32768);
    gain_w  = gn_tmp[42:16];
    vsum    = VS_W'(u_r) + VS_W'(gain_w);
    if (vsum > V_HI) begin
      v_w = V_HI[SAMPLE_BITS-1:0];
    end else if (vsum < V_LO) begin
      v_w = V_LO[SAMPLE_BITS-1:0];
    end else begin
      v_w = vsum[SAMPLE_BITS-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_UP_MUL: begin
        mul_a = MW'(hist_r[dsel_w]);
        mul_b = MW'(asa_tap(up_tap_idx));
      end
      S_ARG_MUL: begin
        mul_a = MW'({1'b0, umag});
        mul_b = MW'({1'b0, freq_r});
      end
      // Quotient estimate from the top argument bits and the scaled reciprocal.
      S_ARG_WAIT: begin
        mul_a = MW'({1'b0, prod[AW-1 -: 28]});
        mul_b = MW'({1'b0, RECIP_PI});
      end
      // Quotient times the upper and the lower half of pi.
      S_QUO: begin
        mul_a = MW'({1'b0, prod[QSH +: QW]});
        mul_b = MW'({1'b0, PI_Q32[33:17]});
      end
      S_REM_HI: begin
        mul_a = MW'({1'b0, q_r});
        mul_b = MW'({1'b0, PI_Q32[16:0]});
      end
      S_SQ_MUL: begin
        mul_a = MW'({1'b0, ay_full[30:0]});
        mul_b = MW'({1'b0, ay_full[30:0]});
      end
      S_GAIN_MUL: begin
        mul_a = MW'({1'b0, inv_mag_r});
        mul_b = MW'({1'b0, s2_r});
      end
      // The last tap product is held while a result waits for the output.
      S_DN_MUL, S_DN_ACC: begin
        mul_a = MW'(v_r);
        mul_b = MW'(asa_tap(t_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  asa_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  asa_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .z_init (cord_z),
    .done   (cord_done),
    .y_out  (cord_y)
  );

  // Sequencer: next state and control strobes.
  logic [3:0] cn_w;
  always_comb begin
    cn_w       = seen_r[4] ? 4'd15 : seen_r[3:0];
    state_nxt  = state_r;
    cord_start = 1'b0;
    emit       = (!out_valid_r || out_tready) ? E_GO : E_WAIT;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tlast || cn_w >= 4'd5)) begin
          state_nxt = S_OUT_INIT;
        end
      end
      S_OUT_INIT: state_nxt = S_UP_INIT;
      S_UP_INIT:  state_nxt = S_UP_MUL;
      S_UP_MUL:   state_nxt = S_UP_ACC;
      S_UP_ACC:   state_nxt = (s_r == 3'd5) ? S_ARG_MUL : S_UP_MUL;
      S_ARG_MUL:  state_nxt = S_ARG_WAIT;
      S_ARG_WAIT: state_nxt = S_QUO;
      S_QUO:      state_nxt = S_REM_HI;
      S_REM_HI:   state_nxt = S_REM_LO;
      S_REM_LO:   state_nxt = S_MOD;
      S_MOD:      state_nxt = S_FOLD;
      S_FOLD: begin
        cord_start = 1'b1;
        state_nxt  = S_CORDIC;
      end
      S_CORDIC:    state_nxt = cord_done ? S_SQ_MUL : S_CORDIC;
      S_SQ_MUL:    state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:   state_nxt = S_GAIN_MUL;
      S_GAIN_MUL:  state_nxt = S_GAIN_WAIT;
      S_GAIN_WAIT: state_nxt = S_DN_MUL;
      S_DN_MUL:    state_nxt = S_DN_ACC;
      S_DN_ACC: begin
        if (t_r != 4'd11) begin
          state_nxt = S_UP_INIT;
        end else if (emit == E_GO) begin
          state_nxt = (o_r == o_end_r) ? S_IDLE : S_OUT_INIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r    <= 24'd65536;
      inv_mag_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SNAKE_FREQ:    freq_r    <= cfg_wdata;
        REG_SNAKE_INV_MAG: inv_mag_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sample count of the running sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (in_fire) begin
      if (in_tlast) begin
        seen_r <= '0;
      end else if (!seen_r[4]) begin
        seen_r <= seen_r + 5'd1;
      end
    end
  end

  // Input history; the first sample of a sequence fills every slot.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int n = 0; n < HIST_DEPTH; n++) begin
        if (seen_r == '0 || n == 0) begin
          hist_r[n] <= $signed(in_tdata);
        end else begin
          hist_r[n] <= hist_r[n-1];
        end
      end
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_n_r <= cn_w;
          last_r  <= in_tlast;
          if (in_tlast) begin
            o_r     <= (cn_w >= 4'd5) ? cn_w - 4'd5 : 4'd0;
            o_end_r <= cn_w;
          end else begin
            o_r     <= cn_w - 4'd5;
            o_end_r <= cn_w - 4'd5;
          end
        end
      end
      S_OUT_INIT: begin
        acc_out_r <= '0;
        t_r       <= '0;
      end
      S_UP_INIT: begin
        acc_up_r <= '0;
        s_r      <= '0;
        k_r      <= jc_w[4:1];
        ph_r     <= jc_w[0];
      end
      S_UP_ACC: begin
        acc_up_r <= acc_up_r + UACC_W'(prod);
        s_r      <= s_r + 3'd1;
      end
      S_ARG_MUL: u_r <= u_w;
      // Remainder: argument less the estimated quotient times pi, in two halves.
      S_ARG_WAIT: rem_r <= prod[AW-1:0];
      S_QUO:      q_r   <= prod[QSH +: QW];
      S_REM_HI:   rem_r <= rem_r - (prod[AW-1:0] << 17);
      S_REM_LO:   rem_r <= rem_r - prod[AW-1:0];
      // The estimate is at most one low, so one subtraction completes it.
      S_MOD: begin
        if (rem_r >= AW'(PI_Q32)) begin
          rem_r <= rem_r - AW'(PI_Q32);
        end
      end
      S_SQ_WAIT:   s2_r <= sq_tmp[61:44];
      S_GAIN_WAIT: v_r  <= v_w;
      S_DN_ACC: begin
        if (t_r != 4'd11) begin
          acc_out_r <= acc_out_r + OACC_W'(prod);
          t_r       <= t_r + 4'd1;
        end else if (emit == E_GO) begin
          o_r <= o_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Full output sum for the result being emitted this cycle.
  logic signed [OACC_W-1:0] acc_fin;
  logic                     load_out;
  assign acc_fin  = acc_out_r + OACC_W'(prod);
  assign load_out = (state_r == S_DN_ACC) && (t_r == 4'd11) && (emit == E_GO);

  logic signed [OACC_W-1:0]      f_rnd;
  logic signed [SAMPLE_BITS-1:0] f_sat;
  always_comb begin
    f_rnd = (acc_fin + OACC_W'(32'sd32768)) >>> 16;
    if (f_rnd > O_HI) begin
      f_sat = O_HI[SAMPLE_BITS-1:0];
    end else if (f_rnd < O_LO) begin
      f_sat = O_LO[SAMPLE_BITS-1:0];
    end else begin
      f_sat = f_rnd[SAMPLE_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= 24'(f_sat);
      out_last_r <= last_r && (o_r == o_end_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `ASA_CHECK_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_tvalid), "reset not idle")
  `ASA_CHECK(a_seen_cleared, (in_fire && in_tlast) |=> (seen_r == 5'd0), "count not cleared")
  `ASA_CHECK(a_out_order, (state_r != S_IDLE) |-> (o_r <= o_end_r), "result index overrun")
  `ASA_CHECK(a_rem_reduced, (state_r == S_FOLD) |-> (rem_r < AW'(PI_Q32)), "modulo incomplete")
  `ASA_CHECK(a_load_valid, load_out |=> out_tvalid, "result not presented")

endmodule

FILE: hdl/asa_mul.sv
// Shared signed multiplier with a registered product.
module asa_mul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p_r
);

  // One product per cycle, available on the next cycle.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

FILE: hdl/asa_cordic.sv
// Iterative rotation CORDIC, one step per cycle, giving the sine in Q30.
module asa_cordic import asa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] z_init,
  output logic                 done,
  output logic signed [CW-1:0] y_out
);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [3:0]           i_r;
  logic                 run_r, done_r;
  logic signed [CW-1:0] dx, dy, at;

  // Shifted cross terms and the angle of this step.
  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = asa_atan(i_r);
  end

  // Run control: sixteen steps after a start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && i_r == 4'd15) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Rotation datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_X0;
      y_r <= '0;
      z_r <= z_init;
      i_r <= '0;
    end else if (run_r) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      i_r <= i_r + 4'd1;
    end
  end

  assign done  = done_r;
  assign y_out = y_r;

endmodule

FILE: dv/antialiased_snake_activation_core_tb.sv
// Self-checking testbench for the anti-aliased snake activation core.
`timescale 1ns / 1ps
module antialiased_snake_activation_core_tb;
  import asa_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [23:0]      in_tdata;   // [23:0] sample_in
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [23:0]      out_tdata;  // [23:0] sample_out
  logic             out_tlast;
  logic             cfg_we;
  logic             cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  antialiased_snake_activation_core uut (.*);

  // Activation predictor and the queue of expected output items.
  class snake_scoreboard;
    longint unsigned freq_q16;
    longint unsigned gain_q16;
    longint          hist[12];
    int              seen;
    int              newest;
    logic [23:0]     exp_sample[$];
    logic            exp_last[$];
    int              errors;

    function new();
      freq_q16 = 65536;
      gain_q16 = 65536;
      seen = 0;
      newest = 0;
      errors = 0;
      foreach (hist[i]) hist[i] = 0;
    endfunction

    function void set_reg(logic addr, longint unsigned val);
      if (addr == REG_SNAKE_FREQ) freq_q16 = val & 24'hFFFFFF;
      else gain_q16 = val & 24'hFFFFFF;
    endfunction

    // Floor shift and round-half-up shift on signed 64-bit values.
    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function longint rshr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint tap(int i);
      case (i)
        0, 11: return 133;
        1, 10: return 615;
        2, 9:  return -1674;
        3, 8:  return -3779;
        4, 7:  return 8426;
        default: return 29046;
      endcase
    endfunction

    function longint atan_q30(int i);
      longint tbl[16];
      tbl = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
              16775851, 8388438, 4194283, 2097149, 1048576, 524288,
              262144, 131072, 65536, 32768};
      return tbl[i];
    endfunction

    function longint sample_at(int i);
      int d;
      if (i < 0) i = 0;
      if (i > newest) i = newest;
      d = newest - i;
      if (d >= 12) d = 11;
      return hist[d];
    endfunction

    // Value plus inv_mag * sin^2(freq * value), through a Q30 CORDIC.
    function longint activate(longint u);
      longint unsigned mag, arg, ay, s2, g;
      longint r, x, y, z, dx, dy;
      mag = (u < 0) ? -u : u;
      arg = mag * freq_q16;
      r = longint'(arg % 64'd13493037705);
      if (r > 64'sd6746518852) r -= 64'sd13493037705;
      z = rshr(r, 2);
      x = 652032875;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = fshr(y, i);
        dy = fshr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q30(i);
        end else begin
          x += dx; y -= dy; z += atan_q30(i);
        end
      end
      ay = (y < 0) ? -y : y;
      s2 = (ay * ay + (64'd1 << 43)) >> 44;
      g = (gain_q16 * s2 + (64'd1 << 15)) >> 16;
      return clip(u + longint'(g));
    endfunction

    function longint upsampled(int j);
      longint acc;
      int k;
      acc = 0;
      if (j < 0) j = 0;
      if (j > 2 * newest + 1) j = 2 * newest + 1;
      k = j / 2;
      for (int s = 0; s < 6; s++) begin
        if ((j & 1) == 0) acc += tap(2 * s + 1) * sample_at(k + 2 - s);
        else acc += tap(2 * s) * sample_at(k + 3 - s);
      end
      return activate(clip(rshr(acc, 15)));
    endfunction

    function logic [23:0] decimated(int o);
      longint acc;
      acc = 0;
      for (int t = 0; t < 12; t++) acc += tap(t) * upsampled(2 * o - 5 + t);
      return 24'(clip(rshr(acc, 16)));
    endfunction

    // Note an accepted input item and queue the outputs it causes.
    function void note_input(logic [23:0] data, logic last);
      longint xs;
      int first;
      xs = longint'(signed'(data));
      if (seen == 0) begin
        foreach (hist[i]) hist[i] = xs;
      end else begin
        for (int i = 11; i > 0; i--) hist[i] = hist[i - 1];
        hist[0] = xs;
      end
      if (seen < 16) seen++;
      newest = seen - 1;
      if (!last) begin
        if (newest >= 5) begin
          exp_sample.push_back(decimated(newest - 5));
          exp_last.push_back(1'b0);
        end
      end else begin
        first = (newest > 5) ? newest - 5 : 0;
        for (int o = first; o <= newest; o++) begin
          exp_sample.push_back(decimated(o));
          exp_last.push_back(o == newest);
        end
        foreach (hist[i]) hist[i] = 0;
        seen = 0;
        newest = 0;
      end
    endfunction

    // Compare an accepted output item with the oldest expectation.
    function void check_output(logic [23:0] data, logic last);
      if (exp_sample.size() == 0) begin
        $display("%0t: unexpected output item sample=%h last=%b", $time, data, last);
        errors++;
        return;
      end
      if (exp_sample[0] !== data) begin
        $display("%0t: sample_out mismatch expected %h actual %h",
                 $time, exp_sample[0], data);
        errors++;
      end
      if (exp_last[0] !== last) begin
        $display("%0t: last_out mismatch expected %b actual %b",
                 $time, exp_last[0], last);
        errors++;
      end
      void'(exp_sample.pop_front());
      void'(exp_last.pop_front());
    endfunction
  endclass

  snake_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_out = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

  // Check every output item accepted at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);
  end

  // Receiver: random stalls, plus a long hold while the block fills up.
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_tready <= 0;
        repeat (4000) @(posedge clk);
        hold_out = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic addr, logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_addr <= addr; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(addr, val);
  endtask

  // Offer one item and hold it until accepted, with an optional gap first.
  task automatic send_sample(logic [23:0] data, logic last);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= data; in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(data, last);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.exp_sample.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(0, 24'h3FFFF) - 24'h20000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  initial begin
    int len;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, a one-sample run, a short run and a long run.
    send_sample(24'h7FFFFF, 1);
    send_sample(24'h800000, 0);
    send_sample(24'h000000, 0);
    send_sample(24'h7FFFFF, 1);
    for (int i = 0; i < 18; i++) send_sample((i & 1) ? 24'h800000 : 24'h7FFFFF, i == 17);
    drain();

    // Sweep register settings, the extremes included.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin write_reg(REG_SNAKE_FREQ, 24'hFFFFFF); write_reg(REG_SNAKE_INV_MAG, 24'hFFFFFF); end
        1: begin write_reg(REG_SNAKE_FREQ, 24'd0); write_reg(REG_SNAKE_INV_MAG, 24'd0); end
        2: begin write_reg(REG_SNAKE_FREQ, 24'h555555); write_reg(REG_SNAKE_INV_MAG, 24'hAAAAAA); end
        default: begin
          write_reg(REG_SNAKE_FREQ, 24'($urandom));
          write_reg(REG_SNAKE_INV_MAG, 24'($urandom));
        end
      endcase
      if (p == 1) hold_out = 1;
      idle_on = (p != 4);
      for (int r = 0; r < 6; r++) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        send_run(len);
      end
      drain();
    end

    if (sb.errors == 0 && sb.exp_sample.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
